// File: rtl/tlvr_pkg.sv
// tlvr_pkg: shared types and constants for the tlv record reader
// no dependencies; imported by the top level and its checker
`timescale 1ns / 1ps

package tlvr_pkg;

	// largest buffer the reader follows, and widths that follow from it
	localparam int MAX_BUFFER_BYTES = 65536;
	localparam int SIZE_W = 17;
	localparam int POS_W = $clog2(MAX_BUFFER_BYTES + 1);
	localparam int CMP_W = ((POS_W > SIZE_W) ? POS_W : SIZE_W) + 1;
	localparam int HDR_BYTES = 8;
	localparam int HIDX_W = 3;

	// output queue holding results that wait for the consumer
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	// request kinds on the input side
	typedef enum logic {
		REQ_START = 1'b0,
		REQ_BYTE  = 1'b1
	} req_t;

	// result kinds on the output side
	typedef enum logic [2:0] {
		K_HDR   = 3'd0,
		K_END   = 3'd1,
		K_TRUNC = 3'd2,
		K_OVF   = 3'd3,
		K_BYTE  = 3'd4
	} kind_t;

	// parser phase, one-hot
	typedef enum logic [2:0] {
		PH_HALT = 3'b001,
		PH_HDR  = 3'b010,
		PH_PAY  = 3'b100
	} phase_t;

	typedef struct packed {
		kind_t        kind;
		logic [15:0]  tag;
		logic [31:0]  length;
		logic [7:0]   data;
		logic         done;
		logic         last;
	} result_t;

endpackage

// File: rtl/tlv_record_reader.sv
// tlv_record_reader: tag-length-value record parser, one buffer byte per transaction
// depends on tlvr_pkg
`timescale 1ns / 1ps

// channel   | direction | tdata                                          | tuser                  | tlast
// s_axis    | in        | [7:0] in_byte                                  | [0] req_type           | -
// m_axis    | out       | [15:0] tag, [47:16] length, [55:48] payload    | [2:0] kind, [3] done   | run_last
// cfg       | in        | cfg_wdata[16:0] buffer_size, written on cfg_we | -                      | -
//
// one input transaction is taken per cycle while s_axis_tready is high; each input
// goes through the input register, then the parse logic into the output queue
// an input yields up to two results; the output side drains one per cycle while
// m_axis_tready is high, and the four-entry output queue sets how far a burst of
// two-result inputs runs ahead before s_axis_tready drops
// arst_n clears the parser to halted with position, header and payload counts at zero
// a stall on m_axis fills the queue and then backs up into the input register

module tlv_record_reader
	import tlvr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [SIZE_W-1:0]    cfg_wdata,      // buffer_size
	// input stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,   // [7:0] in_byte
	input  logic                 s_axis_tuser,   // [0] req_type
	// result stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [55:0]          m_axis_tdata,   // [15:0] record_tag, [47:16] record_length,
	                                             // [55:48] payload_byte
	output logic [3:0]           m_axis_tuser,   // [2:0] kind, [3] record_done
	output logic                 m_axis_tlast    // run_last
);

	// configuration register
	logic [SIZE_W-1:0] buffer_size_q;

	// input register
	logic        valid_s1;
	req_t        req_s1;
	logic [7:0]  byte_s1;

	// parser state
	phase_t              phase_q, phase_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [HIDX_W-1:0]   hidx_q, hidx_d;
	logic [15:0]         tag_q, tag_d;
	logic [31:0]         len_q, len_d;
	logic [POS_W-1:0]    left_q, left_d;

	// output queue
	result_t               oq_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [OQ_CNT_W-1:0]   count_q;

	logic       advance, pop;
	logic [1:0] n_res;
	result_t    res0, res1;

	// size and boundary checks
	logic [CMP_W-1:0] size_ext, size_eff, pos_b, remain;
	logic             bnd_end, bnd_trunc, hdr_ovf;
	logic [15:0]      tag_upd;
	logic [31:0]      len_upd;
	logic [POS_W-1:0] left_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= '0;
		end else if (cfg_we) begin
			buffer_size_q <= cfg_wdata;
		end
	end

	// the parse stage moves when the queue has room for two results
	assign advance = valid_s1 && (count_q <= OQ_CNT_W'(OQ_DEPTH - 2));
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_s1  <= req_t'(s_axis_tuser);
			byte_s1 <= s_axis_tdata;
		end
	end

	// buffer size saturated at the largest supported buffer
	assign size_ext = CMP_W'(buffer_size_q);
	assign size_eff = (size_ext > CMP_W'(MAX_BUFFER_BYTES)) ? CMP_W'(MAX_BUFFER_BYTES)
	                                                        : size_ext;

	// position after this transaction: zero on start, one further on a byte
	assign pos_b  = (req_s1 == REQ_START) ? '0 : CMP_W'(pos_q) + CMP_W'(1);
	assign remain = size_eff - pos_b;

	// record boundary: nothing left, or not enough left for a header
	assign bnd_end   = (pos_b == size_eff);
	assign bnd_trunc = !bnd_end && ((pos_b > size_eff) || (remain < CMP_W'(HDR_BYTES)));

	// header bytes land in tag (bytes 0 and 1) or length (bytes 4 to 7), rest reserved
	always_comb begin
		tag_upd = tag_q;
		len_upd = len_q;
		case (hidx_q)
			3'd0: tag_upd[7:0]   = byte_s1;
			3'd1: tag_upd[15:8]  = byte_s1;
			3'd4: len_upd[7:0]   = byte_s1;
			3'd5: len_upd[15:8]  = byte_s1;
			3'd6: len_upd[23:16] = byte_s1;
			3'd7: len_upd[31:24] = byte_s1;
			default: ;
		endcase
	end

	// length must fit in what remains after the header
	assign hdr_ovf  = (pos_b > size_eff) || (len_upd > 32'(remain));
	assign left_dec = left_q - POS_W'(1);

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		hidx_d  = hidx_q;
		tag_d   = tag_q;
		len_d   = len_q;
		left_d  = left_q;
		n_res   = 2'd0;
		res0    = '0;
		res1    = '0;
		if (req_s1 == REQ_START) begin
			pos_d  = '0;
			hidx_d = '0;
			tag_d  = '0;
			len_d  = '0;
			left_d = '0;
			res0.kind = bnd_end ? K_END : K_TRUNC;
			if (bnd_end || bnd_trunc) begin
				n_res   = 2'd1;
				phase_d = PH_HALT;
			end else begin
				phase_d = PH_HDR;
			end
		end else begin
			unique case (phase_q)
				PH_HDR: begin
					pos_d  = POS_W'(pos_b);
					hidx_d = hidx_q + HIDX_W'(1);
					tag_d  = tag_upd;
					len_d  = len_upd;
					res0.tag    = tag_upd;
					res0.length = len_upd;
					res1.tag    = tag_upd;
					res1.length = len_upd;
					if (hidx_q == HIDX_W'(HDR_BYTES - 1)) begin
						n_res = 2'd1;
						if (hdr_ovf) begin
							res0.kind = K_OVF;
							phase_d   = PH_HALT;
						end else begin
							res0.kind = K_HDR;
							if (len_upd == '0) begin
								// empty record: boundary check in the same transaction
								res1.kind = bnd_end ? K_END : K_TRUNC;
								if (bnd_end || bnd_trunc) begin
									n_res   = 2'd2;
									phase_d = PH_HALT;
								end else begin
									phase_d = PH_HDR;
									hidx_d  = '0;
								end
							end else begin
								left_d  = len_upd[POS_W-1:0];
								phase_d = PH_PAY;
							end
						end
					end
				end
				PH_PAY: begin
					pos_d  = POS_W'(pos_b);
					left_d = left_dec;
					n_res  = 2'd1;
					res0.kind   = K_BYTE;
					res0.tag    = tag_q;
					res0.length = len_q;
					res0.data   = byte_s1;
					res1.tag    = tag_q;
					res1.length = len_q;
					if (left_dec == '0) begin
						// last payload byte closes the record
						res0.done = 1'b1;
						res1.kind = bnd_end ? K_END : K_TRUNC;
						if (bnd_end || bnd_trunc) begin
							n_res   = 2'd2;
							phase_d = PH_HALT;
						end else begin
							phase_d = PH_HDR;
							hidx_d  = '0;
						end
					end
				end
				PH_HALT: ;
				default: ;
			endcase
		end
		res0.last = (n_res == 2'd1);
		res1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HALT;
			pos_q   <= '0;
			hidx_q  <= '0;
			tag_q   <= '0;
			len_q   <= '0;
			left_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			hidx_q  <= hidx_d;
			tag_q   <= tag_d;
			len_q   <= len_d;
			left_q  <= left_d;
		end
	end

	// output queue: up to two writes per cycle, one read
	assign pop = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk) begin
		if (advance && (n_res != 2'd0)) begin
			oq_q[wr_ptr_q] <= res0;
		end
		if (advance && (n_res == 2'd2)) begin
			oq_q[wr_ptr_q + OQ_PTR_W'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (advance) begin
				wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
			end
			count_q <= count_q + (advance ? OQ_CNT_W'(n_res) : '0) - OQ_CNT_W'(pop);
		end
	end

	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata  = {oq_q[rd_ptr_q].data, oq_q[rd_ptr_q].length, oq_q[rd_ptr_q].tag};
	assign m_axis_tuser  = {oq_q[rd_ptr_q].done, oq_q[rd_ptr_q].kind};
	assign m_axis_tlast  = oq_q[rd_ptr_q].last;

endmodule

// File: rtl/tlvr_checker.sv
// tlvr_checker: port-level assertions for the tlv record reader, bound to the top level
// depends on tlvr_pkg
`timescale 1ns / 1ps

module tlvr_checker
	import tlvr_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              cfg_we,
	input logic [SIZE_W-1:0] cfg_wdata,
	input logic              s_axis_tvalid,
	input logic              s_axis_tready,
	input logic [7:0]        s_axis_tdata,
	input logic              s_axis_tuser,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [55:0]       m_axis_tdata,
	input logic [3:0]        m_axis_tuser,
	input logic              m_axis_tlast
);

	// stalled transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// record done only on a payload byte
	a_done_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tuser[2:0] == K_BYTE)
		else $error("record done on a non-payload result");

	// payload field is zero unless a payload byte is carried
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[2:0] != K_BYTE) |-> m_axis_tdata[55:48] == 8'd0)
		else $error("payload field set on a non-payload result");

	// end, truncated and overflow halt the parser and close the run
	a_halt_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ((m_axis_tuser[2:0] == K_END) || (m_axis_tuser[2:0] == K_TRUNC)
			|| (m_axis_tuser[2:0] == K_OVF)) |-> m_axis_tlast)
		else $error("halting result not last of its run");

endmodule

bind tlv_record_reader tlvr_checker u_tlvr_checker (.*);
